/* rtl/quaternion_arithmetic_unit_top_macros.svh */
// Assertion macros for the quaternion unit top-level RTL.
`ifndef QUATERNION_ARITHMETIC_UNIT_TOP_MACROS_SVH
`define QUATERNION_ARITHMETIC_UNIT_TOP_MACROS_SVH
`ifndef ASSERT_OFF
`define QAU_ASSERT(lbl, ck, rn, pre, post) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (pre) |-> (post)) \
    else $error("%m: check failed");
`define QAU_ASSERT_NX(lbl, ck, rn, pre, post) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (pre) |=> (post)) \
    else $error("%m: check failed");
`else
`define QAU_ASSERT(lbl, ck, rn, pre, post)
`define QAU_ASSERT_NX(lbl, ck, rn, pre, post)
`endif
`endif

/* rtl/qau_pkg.sv */
// Shared types and defaults for the quaternion arithmetic unit.
`default_nettype none
package qau_pkg;
  localparam int WORD_BITS_DEF = 32;
  localparam int FRAC_BITS_DEF = 16;

  typedef enum logic [3:0] {
    OP_ADD       = 4'd0,
    OP_SUB       = 4'd1,
    OP_MUL       = 4'd2,
    OP_SCALE     = 4'd3,
    OP_DIV       = 4'd4,
    OP_CONJ      = 4'd5,
    OP_NORMALIZE = 4'd6,
    OP_NORM      = 4'd7,
    OP_NORM_SQ   = 4'd8
  } op_t;

  typedef struct packed {
    logic vld;
    op_t  op;
  } ctl_t;
endpackage
`default_nettype wire

/* rtl/qau_prod.sv */
// Front pipeline: products, sums and the results that need no divide or root.
`default_nettype none
module qau_prod import qau_pkg::*; #(
  parameter int W = WORD_BITS_DEF,
  parameter int F = FRAC_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                en,
  input  ctl_t                i_ctl,
  input  logic signed [W-1:0] i_a [4],
  input  logic signed [W-1:0] i_b [4],
  input  logic signed [W-1:0] i_f,
  output ctl_t                o_ctl,
  output logic [2*W+1:0]      o_sum,
  output logic signed [W-1:0] o_a [4],
  output logic signed [W-1:0] o_f,
  output logic [W-1:0]        o_dr [4],
  output logic [W-2:0]        o_scal,
  output logic                o_dz
);
  localparam int LO_W = W / 2;
  localparam int HI_W = W - LO_W;
  localparam int PL_W = W + LO_W + 1;
  localparam int PH_W = W + HI_W;
  localparam int P_W  = 2 * W;
  localparam int S_W  = 2 * W + 2;

  // Hamilton product operand map: a index, b index per result lane and slot
  localparam logic [1:0] MA [4][4] = '{'{2'd3, 2'd0, 2'd1, 2'd2}, '{2'd3, 2'd1, 2'd2, 2'd0},
                                      '{2'd3, 2'd2, 2'd0, 2'd1}, '{2'd3, 2'd0, 2'd1, 2'd2}};
  localparam logic [1:0] MB [4][4] = '{'{2'd0, 2'd3, 2'd2, 2'd1}, '{2'd1, 2'd3, 2'd0, 2'd2},
                                      '{2'd2, 2'd3, 2'd1, 2'd0}, '{2'd3, 2'd0, 2'd1, 2'd2}};

  logic signed [W-1:0]    pa [4][4];
  logic signed [W-1:0]    pb [4][4];
  logic signed [PL_W-1:0] pl_nxt [4][4];
  logic signed [PH_W-1:0] ph_nxt [4][4];
  logic signed [S_W-1:0]  t [4][4];
  logic [W-1:0]           dr_nxt [4];
  logic [W-2:0]           scal_nxt;
  logic                   dz_nxt;
  logic [S_W-1:0]         nsq;

  ctl_t                   ctl1_r, ctl2_r, ctl3_r, ctl4_r, ctl5_r;
  logic signed [W-1:0]    a1_r [4], a2_r [4], a3_r [4], a4_r [4], a5_r [4];
  logic signed [W-1:0]    b1_r [4], b2_r [4], b3_r [4], b4_r [4];
  logic signed [W-1:0]    f1_r, f2_r, f3_r, f4_r, f5_r;
  logic signed [PL_W-1:0] pl_r [4][4];
  logic signed [PH_W-1:0] ph_r [4][4];
  logic signed [P_W-1:0]  p_r [4][4];
  logic signed [S_W-1:0]  pr_r [4][2];
  logic signed [S_W-1:0]  sum_r [4];
  logic [S_W-1:0]         sum5_r;
  logic [W-1:0]           dr_r [4];
  logic [W-2:0]           scal_r;
  logic                   dz_r;

  function automatic logic [W-1:0] sat_w(input logic signed [S_W-1:0] v);
    logic [S_W-W:0] hi;
    hi = v[S_W-1:W-1];
    if (hi == '0 || hi == '1) begin
      sat_w = v[W-1:0];
    end else if (v[S_W-1]) begin
      sat_w = {1'b1, {(W-1){1'b0}}};
    end else begin
      sat_w = {1'b0, {(W-1){1'b1}}};
    end
  endfunction

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      for (int j = 0; j < 4; j++) begin
        pa[k][j] = '0;
        pb[k][j] = '0;
      end
    end
    case (i_ctl.op)
      OP_MUL: begin
        for (int k = 0; k < 4; k++) begin
          for (int j = 0; j < 4; j++) begin
            pa[k][j] = i_a[MA[k][j]];
            pb[k][j] = i_b[MB[k][j]];
          end
        end
      end
      OP_SCALE: begin
        for (int k = 0; k < 4; k++) begin
          pa[k][0] = i_a[k];
          pb[k][0] = i_f;
        end
      end
      OP_NORMALIZE, OP_NORM, OP_NORM_SQ: begin
        for (int j = 0; j < 4; j++) begin
          pa[0][j] = i_a[j];
          pb[0][j] = i_a[j];
        end
      end
      default: begin
      end
    endcase
    // split b into unsigned low half and signed high half
    for (int k = 0; k < 4; k++) begin
      for (int j = 0; j < 4; j++) begin
        pl_nxt[k][j] = PL_W'(pa[k][j]) * PL_W'($signed({1'b0, pb[k][j][LO_W-1:0]}));
        ph_nxt[k][j] = PH_W'(pa[k][j]) * PH_W'($signed(pb[k][j][W-1:LO_W]));
      end
    end
  end

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      for (int j = 0; j < 4; j++) begin
        t[k][j] = S_W'(p_r[k][j]);
        if (ctl2_r.op == OP_MUL && ((k < 3) ? (j == 3) : (j != 0))) begin
          t[k][j] = -S_W'(p_r[k][j]);
        end
      end
    end
  end

  always_comb begin
    nsq = $unsigned(sum_r[0]) >> F;
    scal_nxt = '0;
    dz_nxt = 1'b0;
    for (int k = 0; k < 4; k++) begin
      dr_nxt[k] = '0;
      case (ctl4_r.op)
        OP_ADD:   dr_nxt[k] = sat_w(S_W'(a4_r[k]) + S_W'(b4_r[k]));
        OP_SUB:   dr_nxt[k] = sat_w(S_W'(a4_r[k]) - S_W'(b4_r[k]));
        OP_MUL, OP_SCALE: dr_nxt[k] = sat_w(sum_r[k] >>> F);
        OP_CONJ:  dr_nxt[k] = (k == 3) ? a4_r[k] : sat_w(-S_W'(a4_r[k]));
        default:  dr_nxt[k] = '0;
      endcase
    end
    case (ctl4_r.op)
      OP_NORM_SQ: scal_nxt = (|nsq[S_W-1:W-1]) ? '1 : nsq[W-2:0];
      OP_DIV:     dz_nxt = (f4_r == '0);
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl1_r <= '0;
      ctl2_r <= '0;
      ctl3_r <= '0;
      ctl4_r <= '0;
      ctl5_r <= '0;
    end else if (en) begin
      ctl1_r <= i_ctl;
      ctl2_r <= ctl1_r;
      ctl3_r <= ctl2_r;
      ctl4_r <= ctl3_r;
      ctl5_r <= ctl4_r;
      a1_r <= i_a;
      a2_r <= a1_r;
      a3_r <= a2_r;
      a4_r <= a3_r;
      a5_r <= a4_r;
      b1_r <= i_b;
      b2_r <= b1_r;
      b3_r <= b2_r;
      b4_r <= b3_r;
      f1_r <= i_f;
      f2_r <= f1_r;
      f3_r <= f2_r;
      f4_r <= f3_r;
      f5_r <= f4_r;
      pl_r <= pl_nxt;
      ph_r <= ph_nxt;
      for (int k = 0; k < 4; k++) begin
        for (int j = 0; j < 4; j++) begin
          p_r[k][j] <= $signed({ph_r[k][j], {LO_W{1'b0}}}) + P_W'(pl_r[k][j]);
        end
        pr_r[k][0] <= t[k][0] + t[k][1];
        pr_r[k][1] <= t[k][2] + t[k][3];
        sum_r[k] <= pr_r[k][0] + pr_r[k][1];
      end
      sum5_r <= sum_r[0];
      dr_r <= dr_nxt;
      scal_r <= scal_nxt;
      dz_r <= dz_nxt;
    end
  end

  assign o_ctl  = ctl5_r;
  assign o_sum  = sum5_r;
  assign o_a    = a5_r;
  assign o_f    = f5_r;
  assign o_dr   = dr_r;
  assign o_scal = scal_r;
  assign o_dz   = dz_r;
endmodule
`default_nettype wire

/* rtl/qau_sqrt.sv */
// Pipelined integer square root, one root bit per stage.
`default_nettype none
module qau_sqrt import qau_pkg::*; #(
  parameter int W      = WORD_BITS_DEF,
  parameter int SIDE_W = 1
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  ctl_t              i_ctl,
  input  logic [2*W+1:0]    i_rad,
  input  logic [SIDE_W-1:0] i_side,
  output ctl_t              o_ctl,
  output logic [W:0]        o_root,
  output logic [SIDE_W-1:0] o_side
);
  localparam int N    = W + 1;
  localparam int R_W  = 2 * N;
  localparam int RM_W = N + 3;

  ctl_t              ctl_r  [N];
  logic [R_W-1:0]    rad_r  [N];
  logic [RM_W-1:0]   rem_r  [N];
  logic [N-1:0]      root_r [N];
  logic [SIDE_W-1:0] side_r [N];

  for (genvar i = 0; i < N; i++) begin : g_st
    ctl_t              c_in;
    logic [R_W-1:0]    rad_in;
    logic [RM_W-1:0]   rem_in;
    logic [N-1:0]      root_in;
    logic [SIDE_W-1:0] side_in;
    logic [RM_W-1:0]   rem_sh;
    logic [RM_W-1:0]   trial;

    if (i == 0) begin : g_first
      assign c_in    = i_ctl;
      assign rad_in  = i_rad;
      assign rem_in  = '0;
      assign root_in = '0;
      assign side_in = i_side;
    end else begin : g_next
      assign c_in    = ctl_r[i-1];
      assign rad_in  = rad_r[i-1];
      assign rem_in  = rem_r[i-1];
      assign root_in = root_r[i-1];
      assign side_in = side_r[i-1];
    end

    assign rem_sh = {rem_in[RM_W-3:0], rad_in[R_W-1 -: 2]};
    assign trial  = RM_W'({root_in, 2'b01});

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        ctl_r[i] <= '0;
      end else if (en) begin
        ctl_r[i]  <= c_in;
        rad_r[i]  <= {rad_in[R_W-3:0], 2'b00};
        side_r[i] <= side_in;
        if (rem_sh >= trial) begin
          rem_r[i]  <= rem_sh - trial;
          root_r[i] <= {root_in[N-2:0], 1'b1};
        end else begin
          rem_r[i]  <= rem_sh;
          root_r[i] <= {root_in[N-2:0], 1'b0};
        end
      end
    end
  end

  assign o_ctl  = ctl_r[N-1];
  assign o_root = root_r[N-1];
  assign o_side = side_r[N-1];
endmodule
`default_nettype wire

/* rtl/qau_div.sv */
// Four-lane pipelined restoring divider, one quotient bit per stage.
`default_nettype none
module qau_div import qau_pkg::*; #(
  parameter int W      = WORD_BITS_DEF,
  parameter int F      = FRAC_BITS_DEF,
  parameter int SIDE_W = 1
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  ctl_t              i_ctl,
  input  logic [W-1:0]      i_num [4],
  input  logic [W:0]        i_dvs,
  input  logic [SIDE_W-1:0] i_side,
  output ctl_t              o_ctl,
  output logic [W+F-1:0]    o_quo [4],
  output logic [SIDE_W-1:0] o_side
);
  localparam int Q_W  = W + F;
  localparam int D_W  = W + 1;
  localparam int RM_W = W + 2;

  ctl_t              ctl_r  [Q_W];
  logic [D_W-1:0]    dvs_r  [Q_W];
  logic [SIDE_W-1:0] side_r [Q_W];
  logic [Q_W-1:0]    nq_r   [Q_W][4];
  logic [RM_W-1:0]   rem_r  [Q_W][4];

  for (genvar i = 0; i < Q_W; i++) begin : g_st
    ctl_t              c_in;
    logic [D_W-1:0]    dvs_in;
    logic [SIDE_W-1:0] side_in;
    logic [Q_W-1:0]    nq_in  [4];
    logic [RM_W-1:0]   rem_in [4];
    logic [RM_W-1:0]   rsh    [4];

    if (i == 0) begin : g_first
      assign c_in    = i_ctl;
      assign dvs_in  = i_dvs;
      assign side_in = i_side;
      always_comb begin
        for (int k = 0; k < 4; k++) begin
          nq_in[k]  = {i_num[k], {F{1'b0}}};
          rem_in[k] = '0;
        end
      end
    end else begin : g_next
      assign c_in    = ctl_r[i-1];
      assign dvs_in  = dvs_r[i-1];
      assign side_in = side_r[i-1];
      assign nq_in   = nq_r[i-1];
      assign rem_in  = rem_r[i-1];
    end

    always_comb begin
      for (int k = 0; k < 4; k++) begin
        rsh[k] = {rem_in[k][RM_W-2:0], nq_in[k][Q_W-1]};
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        ctl_r[i] <= '0;
      end else if (en) begin
        ctl_r[i]  <= c_in;
        dvs_r[i]  <= dvs_in;
        side_r[i] <= side_in;
        for (int k = 0; k < 4; k++) begin
          if (rsh[k] >= RM_W'(dvs_in)) begin
            rem_r[i][k] <= rsh[k] - RM_W'(dvs_in);
            nq_r[i][k]  <= {nq_in[k][Q_W-2:0], 1'b1};
          end else begin
            rem_r[i][k] <= rsh[k];
            nq_r[i][k]  <= {nq_in[k][Q_W-2:0], 1'b0};
          end
        end
      end
    end
  end

  assign o_ctl  = ctl_r[Q_W-1];
  assign o_quo  = nq_r[Q_W-1];
  assign o_side = side_r[Q_W-1];
endmodule
`default_nettype wire

/* rtl/quaternion_arithmetic_unit_top.sv */
// Quaternion ALU top: product front end, root and divide pipelines, output skid.
//
// Input channel in_*: opcode, quaternions A and B, scalar factor, all Q16.16 by
// default. One transfer per cycle is accepted while in_ready is high.
// Result channel out_*: quaternion r_x..r_w, r_scalar (norm or norm squared)
// and div_zero. Exactly one result per input transfer, in order.
// Every opcode takes the same path: five product/sum stages, WORD_BITS+1
// square root stages, WORD_BITS+FRAC_BITS divide stages and the output register.
// Throughput is one item per cycle while in_ready is high.
// When the receiver holds out_ready low, the output register keeps its item
// and one more result lands in a skid register; only then does in_ready drop
// and the whole pipeline freeze. Nothing is dropped or repeated.
// Reset (rst_n low, synchronous) empties every stage and both output
// registers; in_ready is high on the first cycle after reset.
`default_nettype none
`include "quaternion_arithmetic_unit_top_macros.svh"
module quaternion_arithmetic_unit_top import qau_pkg::*; #(
  parameter int WORD_BITS = WORD_BITS_DEF,
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [3:0]                  in_opcode,
  input  logic signed [WORD_BITS-1:0] in_a_x,
  input  logic signed [WORD_BITS-1:0] in_a_y,
  input  logic signed [WORD_BITS-1:0] in_a_z,
  input  logic signed [WORD_BITS-1:0] in_a_w,
  input  logic signed [WORD_BITS-1:0] in_b_x,
  input  logic signed [WORD_BITS-1:0] in_b_y,
  input  logic signed [WORD_BITS-1:0] in_b_z,
  input  logic signed [WORD_BITS-1:0] in_b_w,
  input  logic signed [WORD_BITS-1:0] in_factor,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic signed [WORD_BITS-1:0] out_r_x,
  output logic signed [WORD_BITS-1:0] out_r_y,
  output logic signed [WORD_BITS-1:0] out_r_z,
  output logic signed [WORD_BITS-1:0] out_r_w,
  output logic [WORD_BITS-2:0]        out_r_scalar,
  output logic                        out_div_zero
);
  localparam int W       = WORD_BITS;
  localparam int F       = FRAC_BITS;
  localparam int N       = W + 1;
  localparam int Q_W     = W + F;
  localparam int SIDE1_W = 10 * W;
  localparam int SIDE2_W = SIDE1_W + N + 4;

  typedef struct packed {
    logic [W-1:0] x;
    logic [W-1:0] y;
    logic [W-1:0] z;
    logic [W-1:0] w;
    logic [W-2:0] scal;
    logic         dz;
  } res_t;

  logic                en;
  ctl_t                in_ctl;
  logic signed [W-1:0] in_a [4];
  logic signed [W-1:0] in_b [4];

  ctl_t                p_ctl;
  logic [2*W+1:0]      p_sum;
  logic signed [W-1:0] p_a [4];
  logic signed [W-1:0] p_f;
  logic [W-1:0]        p_dr [4];
  logic [W-2:0]        p_scal;
  logic                p_dz;
  logic [SIDE1_W-1:0]  side1;

  ctl_t                s_ctl;
  logic [N-1:0]        s_root;
  logic [SIDE1_W-1:0]  s_side;
  logic signed [W-1:0] s_a [4];
  logic signed [W-1:0] s_f;
  logic [W-1:0]        num [4];
  logic [N-1:0]        dvs;
  logic [3:0]          neg;
  logic [SIDE2_W-1:0]  side2;

  ctl_t                d_ctl;
  logic [Q_W-1:0]      d_quo [4];
  logic [SIDE2_W-1:0]  d_side;
  logic [W-1:0]        d_a [4];
  logic [W-1:0]        d_dr [4];
  logic [W-2:0]        d_scal;
  logic                d_dz;
  logic [N-1:0]        d_root;
  logic [3:0]          d_neg;
  logic [W-1:0]        qs [4];
  logic [W-1:0]        rv [4];
  res_t                res_nxt;

  logic                out_v_r;
  logic                skid_v_r;
  res_t                out_d_r;
  res_t                skid_d_r;

  function automatic logic [W-1:0] mag_w(input logic signed [W-1:0] v);
    mag_w = v[W-1] ? ((~v) + W'(1)) : v;
  endfunction

  function automatic logic [W-1:0] sat_q(input logic [Q_W-1:0] q, input logic ng);
    logic signed [Q_W:0] v;
    logic [Q_W-W+1:0]    hi;
    v = ng ? -$signed({1'b0, q}) : $signed({1'b0, q});
    hi = v[Q_W:W-1];
    if (hi == '0 || hi == '1) begin
      sat_q = v[W-1:0];
    end else if (v[Q_W]) begin
      sat_q = {1'b1, {(W-1){1'b0}}};
    end else begin
      sat_q = {1'b0, {(W-1){1'b1}}};
    end
  endfunction

  assign en       = !skid_v_r;
  assign in_ready = en;
  assign in_ctl   = '{vld: in_valid, op: op_t'(in_opcode)};
  assign in_a     = '{in_a_x, in_a_y, in_a_z, in_a_w};
  assign in_b     = '{in_b_x, in_b_y, in_b_z, in_b_w};

  qau_prod #(.W(W), .F(F)) u_prod (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (en),
    .i_ctl  (in_ctl),
    .i_a    (in_a),
    .i_b    (in_b),
    .i_f    (in_factor),
    .o_ctl  (p_ctl),
    .o_sum  (p_sum),
    .o_a    (p_a),
    .o_f    (p_f),
    .o_dr   (p_dr),
    .o_scal (p_scal),
    .o_dz   (p_dz)
  );

  assign side1 = {p_a[0], p_a[1], p_a[2], p_a[3], p_f,
                  p_dr[0], p_dr[1], p_dr[2], p_dr[3], p_scal, p_dz};

  qau_sqrt #(.W(W), .SIDE_W(SIDE1_W)) u_sqrt (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (en),
    .i_ctl  (p_ctl),
    .i_rad  (p_sum),
    .i_side (side1),
    .o_ctl  (s_ctl),
    .o_root (s_root),
    .o_side (s_side)
  );

  // divisor is the root for normalize, |factor| otherwise
  always_comb begin
    s_f = s_side[6*W-1 -: W];
    for (int k = 0; k < 4; k++) begin
      s_a[k]   = s_side[(10-k)*W-1 -: W];
      num[k]   = mag_w(s_a[k]);
      neg[3-k] = s_a[k][W-1] ^ ((s_ctl.op == OP_DIV) & s_f[W-1]);
    end
    dvs = (s_ctl.op == OP_NORMALIZE) ? s_root : {1'b0, mag_w(s_f)};
  end

  assign side2 = {s_side, s_root, neg};

  qau_div #(.W(W), .F(F), .SIDE_W(SIDE2_W)) u_div (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (en),
    .i_ctl  (s_ctl),
    .i_num  (num),
    .i_dvs  (dvs),
    .i_side (side2),
    .o_ctl  (d_ctl),
    .o_quo  (d_quo),
    .o_side (d_side)
  );

  always_comb begin
    d_neg  = d_side[3:0];
    d_root = d_side[N+3:4];
    d_dz   = d_side[N+4];
    d_scal = d_side[N+4+W-1:N+5];
    for (int k = 0; k < 4; k++) begin
      d_a[k]  = d_side[N+4+(10-k)*W-1 -: W];
      d_dr[k] = d_side[N+4+(5-k)*W-1 -: W];
      qs[k]   = sat_q(d_quo[k], d_neg[3-k]);
      rv[k]   = d_dr[k];
    end
    res_nxt.scal = d_scal;
    res_nxt.dz   = d_dz;
    case (d_ctl.op)
      OP_DIV: begin
        for (int k = 0; k < 4; k++) begin
          rv[k] = d_dz ? d_a[k] : qs[k];
        end
      end
      OP_NORMALIZE: begin
        for (int k = 0; k < 4; k++) begin
          rv[k] = (d_root == '0) ? d_a[k] : qs[k];
        end
      end
      OP_NORM: res_nxt.scal = (|d_root[N-1:W-1]) ? '1 : d_root[W-2:0];
      default: begin
      end
    endcase
    res_nxt.x = rv[0];
    res_nxt.y = rv[1];
    res_nxt.z = rv[2];
    res_nxt.w = rv[3];
  end

  // output register plus one skid entry
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else if (!out_v_r || out_ready) begin
      if (skid_v_r) begin
        out_v_r  <= 1'b1;
        out_d_r  <= skid_d_r;
        skid_v_r <= 1'b0;
      end else begin
        out_v_r <= d_ctl.vld;
        out_d_r <= res_nxt;
      end
    end else if (d_ctl.vld && !skid_v_r) begin
      skid_v_r <= 1'b1;
      skid_d_r <= res_nxt;
    end
  end

  assign out_valid    = out_v_r;
  assign out_r_x      = out_d_r.x;
  assign out_r_y      = out_d_r.y;
  assign out_r_z      = out_d_r.z;
  assign out_r_w      = out_d_r.w;
  assign out_r_scalar = out_d_r.scal;
  assign out_div_zero = out_d_r.dz;

  `QAU_ASSERT(a_skid_needs_out, clk, rst_n, skid_v_r, out_v_r)
  `QAU_ASSERT_NX(a_skid_fill, clk, rst_n, out_v_r && !out_ready && !skid_v_r && d_ctl.vld, skid_v_r)
  `QAU_ASSERT(a_dz_no_scalar, clk, rst_n, out_valid && out_div_zero, out_r_scalar == '0)
endmodule
`default_nettype wire

/* tb/quaternion_arithmetic_unit_top_test.sv */
// Self-checking testbench for the quaternion ALU: directed and random operations, scoreboarded.
module quaternion_arithmetic_unit_top_test;
  import qau_pkg::*;

  typedef struct {
    logic [3:0]         op;
    logic signed [31:0] a [4];
    logic signed [31:0] b [4];
    logic signed [31:0] f;
  } quat_op_t;

  typedef struct {
    logic signed [31:0] r [4];
    logic [30:0]        sc;
    logic               dz;
  } quat_res_t;

  localparam logic signed [127:0] WMAX = 128'sd2147483647;
  localparam logic signed [127:0] WMIN = -128'sd2147483648;

  function automatic logic signed [127:0] wide(logic signed [31:0] v);
    logic signed [127:0] w;
    w = v;
    return w;
  endfunction

  function automatic logic signed [31:0] clamp(logic signed [127:0] v);
    if (v > WMAX) return 32'sh7fffffff;
    if (v < WMIN) return 32'sh80000000;
    return v[31:0];
  endfunction

  // fixed-point quotient, truncated toward zero
  function automatic logic signed [31:0] fx_div(logic signed [127:0] a, logic signed [127:0] d);
    logic signed [127:0] m, dm, q;
    m  = (a < 0) ? -a : a;
    dm = (d < 0) ? -d : d;
    q  = (m <<< 16) / dm;
    if ((a < 0) != (d < 0)) q = -q;
    return clamp(q);
  endfunction

  function automatic logic signed [127:0] dot4(logic signed [127:0] p0, logic signed [127:0] q0,
                                               logic signed [127:0] p1, logic signed [127:0] q1,
                                               logic signed [127:0] p2, logic signed [127:0] q2,
                                               logic signed [127:0] p3, logic signed [127:0] q3);
    return p0 * q0 + p1 * q1 + p2 * q2 - p3 * q3;
  endfunction

  function automatic quat_res_t quat_compute(quat_op_t it);
    quat_res_t           res;
    logic signed [127:0] a [4];
    logic signed [127:0] b [4];
    logic signed [127:0] f, s;
    logic [127:0]        sq, rt, c;
    for (int i = 0; i < 4; i++) begin
      a[i] = wide(it.a[i]);
      b[i] = wide(it.b[i]);
      res.r[i] = '0;
    end
    f = wide(it.f);
    res.sc = '0;
    res.dz = 1'b0;
    sq = a[0] * a[0] + a[1] * a[1] + a[2] * a[2] + a[3] * a[3];
    rt = '0;
    for (int i = 32; i >= 0; i--) begin
      c = rt | (128'd1 << i);
      if (c * c <= sq) rt = c;
    end
    case (it.op)
      OP_ADD: for (int i = 0; i < 4; i++) res.r[i] = clamp(a[i] + b[i]);
      OP_SUB: for (int i = 0; i < 4; i++) res.r[i] = clamp(a[i] - b[i]);
      OP_MUL: begin
        res.r[0] = clamp(dot4(a[3], b[0], a[0], b[3], a[1], b[2], a[2], b[1]) >>> 16);
        res.r[1] = clamp(dot4(a[3], b[1], a[1], b[3], a[2], b[0], a[0], b[2]) >>> 16);
        res.r[2] = clamp(dot4(a[3], b[2], a[2], b[3], a[0], b[1], a[1], b[0]) >>> 16);
        s = a[3] * b[3] - a[0] * b[0] - a[1] * b[1] - a[2] * b[2];
        res.r[3] = clamp(s >>> 16);
      end
      OP_SCALE: for (int i = 0; i < 4; i++) res.r[i] = clamp((a[i] * f) >>> 16);
      OP_DIV: begin
        if (f == 0) begin
          res.dz = 1'b1;
          for (int i = 0; i < 4; i++) res.r[i] = it.a[i];
        end else begin
          for (int i = 0; i < 4; i++) res.r[i] = fx_div(a[i], f);
        end
      end
      OP_CONJ: begin
        for (int i = 0; i < 3; i++) res.r[i] = clamp(-a[i]);
        res.r[3] = it.a[3];
      end
      OP_NORMALIZE: for (int i = 0; i < 4; i++)
        res.r[i] = (rt == 0) ? it.a[i] : fx_div(a[i], $signed(rt));
      OP_NORM: res.sc = (rt > 128'd2147483647) ? 31'h7fffffff : rt[30:0];
      OP_NORM_SQ: begin
        sq = sq >> 16;
        res.sc = (sq > 128'd2147483647) ? 31'h7fffffff : sq[30:0];
      end
      default: ;
    endcase
    return res;
  endfunction

  class quat_scoreboard;
    quat_res_t pending [$];
    int        errors = 0;
    int        checked = 0;

    function void note_input(quat_op_t it);
      pending.push_back(quat_compute(it));
    endfunction

    function void check_result(quat_res_t got);
      quat_res_t want;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result x=%h y=%h z=%h w=%h", $time,
                 got.r[0], got.r[1], got.r[2], got.r[3]);
        errors++;
        return;
      end
      want = pending.pop_front();
      checked++;
      for (int i = 0; i < 4; i++)
        if (got.r[i] !== want.r[i]) begin
          $display("%0t: r[%0d] expected %h got %h", $time, i, want.r[i], got.r[i]);
          errors++;
        end
      if (got.sc !== want.sc) begin
        $display("%0t: r_scalar expected %h got %h", $time, want.sc, got.sc);
        errors++;
      end
      if (got.dz !== want.dz) begin
        $display("%0t: div_zero expected %b got %b", $time, want.dz, got.dz);
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [3:0] in_opcode = '0;
  logic signed [31:0] in_a_x = '0, in_a_y = '0, in_a_z = '0, in_a_w = '0;
  logic signed [31:0] in_b_x = '0, in_b_y = '0, in_b_z = '0, in_b_w = '0;
  logic signed [31:0] in_factor = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [31:0] out_r_x, out_r_y, out_r_z, out_r_w;
  logic [30:0] out_r_scalar;
  logic out_div_zero;

  quaternion_arithmetic_unit_top DUT (.*);

  always #1 clk = ~clk;

  quat_scoreboard sb = new();
  quat_op_t       stim [$];
  quat_op_t       held;
  int             idle_pct = 0;
  int             stall_pct = 0;
  int             sent = 0;
  int             quiet = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        sb.note_input(held);
        sent++;
      end
      if (!in_valid || in_ready) begin
        if (stim.size() > 0 && $urandom_range(99) >= idle_pct) begin
          held = stim.pop_front();
          in_opcode <= held.op;
          in_a_x <= held.a[0]; in_a_y <= held.a[1]; in_a_z <= held.a[2]; in_a_w <= held.a[3];
          in_b_x <= held.b[0]; in_b_y <= held.b[1]; in_b_z <= held.b[2]; in_b_w <= held.b[3];
          in_factor <= held.f;
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    quat_res_t got;
    if (rst_n && out_valid && out_ready) begin
      got.r[0] = out_r_x; got.r[1] = out_r_y; got.r[2] = out_r_z; got.r[3] = out_r_w;
      got.sc = out_r_scalar;
      got.dz = out_div_zero;
      sb.check_result(got);
    end
    out_ready <= rst_n && ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) quiet <= 0;
    else quiet <= quiet + 1;
    if (quiet >= 5000) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  function automatic logic signed [31:0] pick_word();
    case ($urandom_range(5))
      0: return $urandom_range(1) ? 32'sh7fffffff : 32'sh80000000;
      1: return $signed($urandom_range(131072)) - 32'sd65536;
      2: return 32'sd0;
      3: return $signed($urandom_range(16'hffff)) <<< $urandom_range(16);
      default: return $signed($urandom());
    endcase
  endfunction

  function automatic quat_op_t mk(logic [3:0] op, logic signed [31:0] av, logic signed [31:0] bv,
                                  logic signed [31:0] fv);
    quat_op_t it;
    it.op = op;
    for (int i = 0; i < 4; i++) begin
      it.a[i] = av;
      it.b[i] = bv;
    end
    it.f = fv;
    return it;
  endfunction

  function automatic quat_op_t rand_item();
    quat_op_t it;
    it.op = ($urandom_range(19) == 0) ? 4'($urandom_range(9, 15)) : 4'($urandom_range(8));
    for (int i = 0; i < 4; i++) begin
      it.a[i] = pick_word();
      it.b[i] = pick_word();
    end
    it.f = ($urandom_range(9) == 0) ? 32'sd0 : pick_word();
    if (it.op == OP_NORMALIZE && $urandom_range(9) == 0)
      for (int i = 0; i < 4; i++) it.a[i] = 0;
    return it;
  endfunction

  task automatic run_phase(int idle, int stall, int count);
    idle_pct = idle;
    stall_pct = stall;
    for (int i = 0; i < count; i++) stim.push_back(rand_item());
    wait (stim.size() == 0 && !in_valid && sb.pending.size() == 0);
  endtask

  localparam logic signed [31:0] MAXW = 32'sh7fffffff;
  localparam logic signed [31:0] MINW = 32'sh80000000;
  localparam logic signed [31:0] ONE = 32'sh00010000;

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    stim.push_back(mk(OP_ADD, MAXW, MAXW, 0));
    stim.push_back(mk(OP_ADD, MINW, MINW, 0));
    stim.push_back(mk(OP_SUB, MINW, MAXW, 0));
    stim.push_back(mk(OP_SUB, MAXW, MINW, 0));
    stim.push_back(mk(OP_MUL, MINW, MINW, 0));
    stim.push_back(mk(OP_MUL, MAXW, MINW, 0));
    stim.push_back(mk(OP_MUL, ONE, -ONE, 0));
    stim.push_back(mk(OP_SCALE, MINW, 0, MINW));
    stim.push_back(mk(OP_SCALE, -3, 0, 1));
    stim.push_back(mk(OP_DIV, ONE, 0, 0));
    stim.push_back(mk(OP_DIV, MINW, 0, 0));
    stim.push_back(mk(OP_DIV, MINW, 0, -1));
    stim.push_back(mk(OP_DIV, MAXW, 0, MINW));
    stim.push_back(mk(OP_DIV, -7, 0, 3 * ONE));
    stim.push_back(mk(OP_CONJ, MINW, 0, 0));
    stim.push_back(mk(OP_CONJ, MAXW, 0, 0));
    stim.push_back(mk(OP_NORMALIZE, 0, 0, 0));
    stim.push_back(mk(OP_NORMALIZE, MINW, 0, 0));
    stim.push_back(mk(OP_NORMALIZE, 1, 0, 0));
    stim.push_back(mk(OP_NORM, MINW, 0, 0));
    stim.push_back(mk(OP_NORM, 0, 0, 0));
    stim.push_back(mk(OP_NORM_SQ, MAXW, 0, 0));
    stim.push_back(mk(OP_NORM_SQ, ONE, 0, 0));
    stim.push_back(mk(4'd9, MAXW, MAXW, MAXW));
    stim.push_back(mk(4'd15, MINW, MINW, MINW));
    wait (stim.size() == 0 && !in_valid && sb.pending.size() == 0);
    run_phase(0, 0, 350);
    run_phase(86, 0, 250);
    run_phase(0, 86, 250);
    run_phase(24, 24, 350);
    repeat (120) @(posedge clk);
    $display("Ran %0d transfers over all opcodes and unused codes, %0d results checked,",
             sent, sb.checked);
    $display("with sender gaps and receiver stalls alone, together and absent.");
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end
endmodule
